/* rtl/core/styled_markup_run_splitter_defines.svh */
// ----------------------------------------------------------------------------
// Styled markup run splitter assertion macros
// Concurrent assertion wrappers that compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef STYLED_MARKUP_RUN_SPLITTER_DEFINES_SVH
`define STYLED_MARKUP_RUN_SPLITTER_DEFINES_SVH

`ifndef SYNTH
`define SMRS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define SMRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define SMRS_ASSERT_IMPLY(label, ante, cons)
`define SMRS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/core/smrs_pkg.sv */
// ----------------------------------------------------------------------------
// Styled markup run splitter package
// Shared constants, character codes and types of the run splitter.
// ----------------------------------------------------------------------------
package smrs_pkg;

    localparam int GROUPS        = 7;
    localparam int SOURCE_W      = 5;
    localparam int STYLE_ENTRIES = 16;
    localparam int FLAGS_W       = 56;
    localparam int ENTRY_FLAGS_W = 7;

    localparam logic [15:0] MAX_STRING_BYTES = 16'd65535;
    localparam logic [4:0]  UNSET            = 5'd16;

    localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
    localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
    localparam logic [7:0] CHAR_PIPE      = 8'h7C;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_N         = 8'h6E;
    localparam logic [7:0] CHAR_L         = 8'h6C;
    localparam logic [7:0] CHAR_C         = 8'h63;
    localparam logic [7:0] CHAR_R         = 8'h72;
    localparam logic [7:0] CHAR_J         = 8'h6A;
    localparam logic [7:0] CHAR_DIGIT_0   = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9   = 8'h39;
    localparam logic [7:0] RADIX          = 8'd10;

    localparam logic [1:0] ALN_LEFT    = 2'd0;
    localparam logic [1:0] ALN_CENTER  = 2'd1;
    localparam logic [1:0] ALN_RIGHT   = 2'd2;
    localparam logic [1:0] ALN_JUSTIFY = 2'd3;

    localparam logic KIND_TEXT    = 1'b0;
    localparam logic KIND_NEWLINE = 1'b1;

    localparam logic CFG_FLAGS_LOW  = 1'b0;
    localparam logic CFG_FLAGS_HIGH = 1'b1;

    typedef logic [SOURCE_W-1:0] source_t;
    typedef source_t [GROUPS-1:0] sources_t;

    typedef struct packed {
        logic                     hit;
        logic [ENTRY_FLAGS_W-1:0] flags;
    } lookup_t;

    localparam sources_t UNSET_SOURCES = {GROUPS{UNSET}};

endpackage

/* rtl/core/styled_markup_run_splitter.sv */
// ----------------------------------------------------------------------------
// Styled markup run splitter
// Parses a markup string one byte per transaction into text runs and newline
// runs, each tagged with the style entry that supplies each attribute group.
//
// Channel   Direction  Transaction carries
// in        input      text_byte, is_last
// out       output     run_kind, run_begin, run_length, run_align, 7 sources
// cfg       input      cfg_index, cfg_data (style flag words)
//
// Each byte passes an input register, the combinational parse logic and the
// result register before its run is valid on the outputs. One byte is
// accepted per cycle while the result register is empty or being taken.
// Reset clears the parse state and the flag words. When the result register
// is full and not taken, a byte held in the input register stays there and
// in_ready is low.
// ----------------------------------------------------------------------------
`include "styled_markup_run_splitter_defines.svh"

module styled_markup_run_splitter
    import smrs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         text_byte,
    input  logic               is_last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               run_kind,
    output logic [15:0]        run_begin,
    output logic [15:0]        run_length,
    output logic [1:0]         run_align,
    output logic [4:0]         font_source,
    output logic [4:0]         size_source,
    output logic [4:0]         color_source,
    output logic [4:0]         weight_source,
    output logic [4:0]         decoration_source,
    output logic [4:0]         spacing_source,
    output logic [4:0]         shadow_source,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [FLAGS_W-1:0] cfg_data
);

    logic        s_valid_reg;
    logic [7:0]  s_byte_reg;
    logic        s_last_reg;

    logic        in_tag_reg, in_tag_next;
    logic        esc_reg, esc_next;
    logic [15:0] bp_reg, bp_next;
    logic [15:0] ts_reg, ts_next;
    logic [1:0]  tok_len_reg, tok_len_next;
    logic [7:0]  tok_first_reg, tok_first_next;
    source_t     tok_acc_reg, tok_acc_next;
    logic        tok_num_reg, tok_num_next;
    logic [1:0]  align_reg, align_next;
    sources_t    active_reg, active_next;
    sources_t    tag_reg, tag_next;

    logic        out_valid_reg;
    logic        out_kind_reg;
    logic [15:0] out_begin_reg;
    logic [15:0] out_len_reg;
    logic [1:0]  out_align_reg;
    sources_t    out_src_reg;

    logic        emit;
    logic        emit_kind;
    logic [15:0] emit_begin;
    logic [15:0] emit_len;
    logic [1:0]  emit_align;
    sources_t    emit_src;

    logic        can_process;
    logic        fire;
    logic        is_digit;
    logic [7:0]  acc_prod;
    lookup_t     lookup;
    sources_t    merged_tag;

    smrs_style_lookup u_lookup (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .id        (tok_acc_reg),
        .rsp       (lookup)
    );

    assign can_process = !out_valid_reg || out_ready;
    assign fire        = s_valid_reg && can_process;
    assign in_ready    = !s_valid_reg || can_process;

    assign is_digit = (s_byte_reg >= CHAR_DIGIT_0) && (s_byte_reg <= CHAR_DIGIT_9);
    assign acc_prod = 8'(tok_acc_reg) * RADIX + (s_byte_reg - CHAR_DIGIT_0);

    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            merged_tag[g] = (lookup.hit && lookup.flags[g]) ? tok_acc_reg : tag_reg[g];
        end
    end

    always_comb
    begin
        in_tag_next    = in_tag_reg;
        esc_next       = esc_reg;
        bp_next        = bp_reg;
        ts_next        = ts_reg;
        tok_len_next   = tok_len_reg;
        tok_first_next = tok_first_reg;
        tok_acc_next   = tok_acc_reg;
        tok_num_next   = tok_num_reg;
        align_next     = align_reg;
        active_next    = active_reg;
        tag_next       = tag_reg;

        emit       = 1'b0;
        emit_kind  = KIND_TEXT;
        emit_begin = '0;
        emit_len   = '0;
        emit_align = align_reg;
        emit_src   = active_reg;

        if (bp_reg < MAX_STRING_BYTES)
        begin
            bp_next = bp_reg + 16'd1;
            if (!in_tag_reg)
            begin
                if ((s_byte_reg == CHAR_LBRACKET) && !esc_reg)
                begin
                    if (bp_reg > ts_reg)
                    begin
                        emit       = 1'b1;
                        emit_begin = ts_reg;
                        emit_len   = bp_reg - ts_reg;
                    end
                    in_tag_next    = 1'b1;
                    tag_next       = UNSET_SOURCES;
                    tok_len_next   = 2'd0;
                    tok_first_next = '0;
                    tok_acc_next   = '0;
                    tok_num_next   = 1'b1;
                    esc_next       = 1'b0;
                end
                else
                begin
                    esc_next = (s_byte_reg == CHAR_BACKSLASH);
                end
            end
            else if ((s_byte_reg == CHAR_PIPE) || (s_byte_reg == CHAR_RBRACKET))
            begin
                if (tok_len_reg == 2'd1)
                begin
                    unique case (tok_first_reg)
                        CHAR_N:
                        begin
                            emit      = 1'b1;
                            emit_kind = KIND_NEWLINE;
                            emit_src  = tag_reg;
                        end
                        CHAR_L:  align_next = ALN_LEFT;
                        CHAR_C:  align_next = ALN_CENTER;
                        CHAR_R:  align_next = ALN_RIGHT;
                        CHAR_J:  align_next = ALN_JUSTIFY;
                        default: ;
                    endcase
                end
                if (tok_num_reg && (tok_len_reg != 2'd0))
                begin
                    tag_next = merged_tag;
                end
                tok_len_next   = 2'd0;
                tok_first_next = '0;
                tok_acc_next   = '0;
                tok_num_next   = 1'b1;
                if (s_byte_reg == CHAR_RBRACKET)
                begin
                    active_next = tag_next;
                    in_tag_next = 1'b0;
                    esc_next    = 1'b0;
                    ts_next     = bp_next;
                end
            end
            else
            begin
                if (tok_len_reg == 2'd0)
                begin
                    tok_first_next = s_byte_reg;
                end
                if (tok_len_reg != 2'd2)
                begin
                    tok_len_next = tok_len_reg + 2'd1;
                end
                if (tok_num_reg)
                begin
                    if (is_digit)
                    begin
                        tok_acc_next = (acc_prod > 8'(UNSET)) ? UNSET : acc_prod[4:0];
                    end
                    else
                    begin
                        tok_num_next = 1'b0;
                    end
                end
            end
        end

        if (s_last_reg)
        begin
            if (!emit)
            begin
                if (in_tag_next)
                begin
                    if ((tok_len_next == 2'd1) && (tok_first_next == CHAR_N))
                    begin
                        emit       = 1'b1;
                        emit_kind  = KIND_NEWLINE;
                        emit_src   = tag_next;
                        emit_align = align_next;
                    end
                end
                else if (bp_next > ts_next)
                begin
                    emit       = 1'b1;
                    emit_begin = ts_next;
                    emit_len   = bp_next - ts_next;
                    emit_src   = active_next;
                    emit_align = align_next;
                end
            end
            in_tag_next    = 1'b0;
            esc_next       = 1'b0;
            bp_next        = '0;
            ts_next        = '0;
            tok_len_next   = 2'd0;
            tok_first_next = '0;
            tok_acc_next   = '0;
            tok_num_next   = 1'b1;
            align_next     = ALN_LEFT;
            active_next    = UNSET_SOURCES;
            tag_next       = UNSET_SOURCES;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            in_tag_reg    <= 1'b0;
            esc_reg       <= 1'b0;
            bp_reg        <= '0;
            ts_reg        <= '0;
            tok_len_reg   <= 2'd0;
            tok_first_reg <= '0;
            tok_acc_reg   <= '0;
            tok_num_reg   <= 1'b1;
            align_reg     <= ALN_LEFT;
            active_reg    <= UNSET_SOURCES;
            tag_reg       <= UNSET_SOURCES;
        end
        else
        begin
            if (in_ready)
            begin
                s_valid_reg <= in_valid;
            end
            if (can_process)
            begin
                out_valid_reg <= fire && emit;
            end
            if (fire)
            begin
                in_tag_reg    <= in_tag_next;
                esc_reg       <= esc_next;
                bp_reg        <= bp_next;
                ts_reg        <= ts_next;
                tok_len_reg   <= tok_len_next;
                tok_first_reg <= tok_first_next;
                tok_acc_reg   <= tok_acc_next;
                tok_num_reg   <= tok_num_next;
                align_reg     <= align_next;
                active_reg    <= active_next;
                tag_reg       <= tag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s_byte_reg <= text_byte;
            s_last_reg <= is_last;
        end
        if (fire && emit)
        begin
            out_kind_reg  <= emit_kind;
            out_begin_reg <= emit_begin;
            out_len_reg   <= emit_len;
            out_align_reg <= emit_align;
            out_src_reg   <= emit_src;
        end
    end

    assign out_valid         = out_valid_reg;
    assign run_kind          = out_kind_reg;
    assign run_begin         = out_begin_reg;
    assign run_length        = out_len_reg;
    assign run_align         = out_align_reg;
    assign font_source       = out_src_reg[0];
    assign size_source       = out_src_reg[1];
    assign color_source      = out_src_reg[2];
    assign weight_source     = out_src_reg[3];
    assign decoration_source = out_src_reg[4];
    assign spacing_source    = out_src_reg[5];
    assign shadow_source     = out_src_reg[6];

    `SMRS_ASSERT_IMPLY(a_newline_empty, out_valid_reg && (out_kind_reg == KIND_NEWLINE), (out_begin_reg == 16'd0) && (out_len_reg == 16'd0))
    `SMRS_ASSERT_IMPLY(a_text_nonempty, out_valid_reg && (out_kind_reg == KIND_TEXT), out_len_reg != 16'd0)
    `SMRS_ASSERT_IMPLY(a_tag_no_escape, in_tag_reg, !esc_reg)
    `SMRS_ASSERT_IMPLY(a_start_in_range, 1'b1, ts_reg <= bp_reg)
    `SMRS_ASSERT_NEXT(a_last_clears, fire && s_last_reg, (bp_reg == 16'd0) && !in_tag_reg)

endmodule

/* rtl/core/smrs_style_lookup.sv */
// ----------------------------------------------------------------------------
// Style flag table
// Holds the per-entry set flags written over the configuration port and
// returns the seven group flags of one style entry.
// ----------------------------------------------------------------------------
module smrs_style_lookup
    import smrs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [FLAGS_W-1:0] cfg_data,
    input  source_t            id,
    output lookup_t            rsp
);

    logic [FLAGS_W-1:0] flags_low_reg;
    logic [FLAGS_W-1:0] flags_high_reg;
    logic [5:0]         bit_base;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_low_reg  <= '0;
            flags_high_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FLAGS_LOW:  flags_low_reg  <= cfg_data;
                CFG_FLAGS_HIGH: flags_high_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign bit_base = 6'(id[2:0]) * 6'(ENTRY_FLAGS_W);

    always_comb
    begin
        rsp.hit = (id < 5'(STYLE_ENTRIES));
        if (id[3])
        begin
            rsp.flags = flags_high_reg[bit_base +: ENTRY_FLAGS_W];
        end
        else
        begin
            rsp.flags = flags_low_reg[bit_base +: ENTRY_FLAGS_W];
        end
    end

endmodule

/* dv/styled_markup_run_splitter_tb.sv */
// ----------------------------------------------------------------------------
// Styled markup run splitter testbench
// Feeds markup strings one byte per transaction and predicts the text and
// newline runs, with alignment and per-group style sources, in step with every
// accepted byte. Each run from the block is compared field by field with the
// oldest predicted run. The stimulus starts with a short directed string set,
// moves through several flag word settings with random well-formed, broken
// and noise strings, holds the output off long enough to stall the input,
// and ends with one short directed string sent back to back.
// ----------------------------------------------------------------------------
module styled_markup_run_splitter_tb;
    import smrs_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic       kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [1:0]  align;
        sources_t    src;
    } run_t;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } byte_item_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [7:0]         text_byte = '0;
    logic               is_last = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               run_kind;
    logic [15:0]        run_begin;
    logic [15:0]        run_length;
    logic [1:0]         run_align;
    logic [4:0]         font_source;
    logic [4:0]         size_source;
    logic [4:0]         color_source;
    logic [4:0]         weight_source;
    logic [4:0]         decoration_source;
    logic [4:0]         spacing_source;
    logic [4:0]         shadow_source;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = 1'b0;
    logic [FLAGS_W-1:0] cfg_data = '0;

    byte_item_t pending_bytes[$];
    run_t       expected_runs[$];
    logic [7:0] draft[$];
    byte_item_t next_item;
    int         queued_total = 0;
    int         mismatch_count = 0;
    int         quiet_cycles = 0;
    bit         no_idle = 1'b0;
    int         hold_order = 0;
    int         hold_seen;
    int         hold_left;
    int         recv_wait;
    int         send_wait;

    logic [FLAGS_W-1:0] flags_low = '0;
    logic [FLAGS_W-1:0] flags_high = '0;
    bit                 tag_open;
    bit                 escape_armed;
    int                 byte_pos;
    int                 run_start;
    int                 token_len;
    logic [7:0]         token_head;
    int                 token_value;
    bit                 token_is_number;
    logic [1:0]         align_now;
    sources_t           text_src;
    sources_t           tag_src;

    styled_markup_run_splitter dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .text_byte         (text_byte),
        .is_last           (is_last),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .run_kind          (run_kind),
        .run_begin         (run_begin),
        .run_length        (run_length),
        .run_align         (run_align),
        .font_source       (font_source),
        .size_source       (size_source),
        .color_source      (color_source),
        .weight_source     (weight_source),
        .decoration_source (decoration_source),
        .spacing_source    (spacing_source),
        .shadow_source     (shadow_source),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void clear_token();
        token_len = 0;
        token_head = '0;
        token_value = 0;
        token_is_number = 1'b1;
    endfunction

    function automatic void reset_parse();
        tag_open = 1'b0;
        escape_armed = 1'b0;
        byte_pos = 0;
        run_start = 0;
        align_now = ALN_LEFT;
        clear_token();
        text_src = UNSET_SOURCES;
        tag_src = UNSET_SOURCES;
    endfunction

    function automatic void apply_entry(input int id);
        logic [FLAGS_W-1:0] word;
        if (id >= STYLE_ENTRIES)
            return;
        if (id < 8)
            word = flags_low >> (ENTRY_FLAGS_W * id);
        else
            word = flags_high >> (ENTRY_FLAGS_W * (id - 8));
        for (int g = 0; g < GROUPS; g++)
            if (word[g])
                tag_src[g] = source_t'(id);
    endfunction

    function automatic run_t make_run(input logic kind, input int start, input int len,
                                      input sources_t src);
        run_t r;
        r.kind = kind;
        r.start = start[15:0];
        r.len = len[15:0];
        r.align = align_now;
        r.src = src;
        return r;
    endfunction

    function automatic bit close_token(output run_t r);
        bit made;
        made = 1'b0;
        r = '0;
        if (token_len == 1)
        begin
            case (token_head)
                CHAR_N:
                begin
                    r = make_run(KIND_NEWLINE, 0, 0, tag_src);
                    made = 1'b1;
                end
                CHAR_L: align_now = ALN_LEFT;
                CHAR_C: align_now = ALN_CENTER;
                CHAR_R: align_now = ALN_RIGHT;
                CHAR_J: align_now = ALN_JUSTIFY;
                default:
                    if (token_head >= CHAR_DIGIT_0 && token_head <= CHAR_DIGIT_9)
                        apply_entry(int'(token_head) - int'(CHAR_DIGIT_0));
            endcase
        end
        else if (token_len >= 2 && token_is_number)
            apply_entry(token_value);
        clear_token();
        return made;
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic last);
        run_t r;
        bit   made;
        int   p;
        made = 1'b0;
        r = '0;
        if (byte_pos < int'(MAX_STRING_BYTES))
        begin
            p = byte_pos;
            byte_pos = p + 1;
            if (!tag_open)
            begin
                if (b == CHAR_LBRACKET && !escape_armed)
                begin
                    if (p > run_start)
                    begin
                        r = make_run(KIND_TEXT, run_start, p - run_start, text_src);
                        made = 1'b1;
                    end
                    tag_open = 1'b1;
                    tag_src = UNSET_SOURCES;
                    clear_token();
                    escape_armed = 1'b0;
                end
                else
                    escape_armed = (b == CHAR_BACKSLASH);
            end
            else if (b == CHAR_PIPE || b == CHAR_RBRACKET)
            begin
                made = close_token(r);
                if (b == CHAR_RBRACKET)
                begin
                    text_src = tag_src;
                    tag_open = 1'b0;
                    escape_armed = 1'b0;
                    run_start = p + 1;
                end
            end
            else
            begin
                if (token_len == 0)
                    token_head = b;
                if (token_len < 2)
                    token_len++;
                if (token_is_number)
                begin
                    if (b >= CHAR_DIGIT_0 && b <= CHAR_DIGIT_9)
                    begin
                        token_value = token_value * int'(RADIX) + int'(b) - int'(CHAR_DIGIT_0);
                        if (token_value > int'(UNSET))
                            token_value = int'(UNSET);
                    end
                    else
                        token_is_number = 1'b0;
                end
            end
        end
        if (last)
        begin
            if (!made)
            begin
                if (tag_open)
                    made = close_token(r);
                else if (byte_pos > run_start)
                begin
                    r = make_run(KIND_TEXT, run_start, byte_pos - run_start, text_src);
                    made = 1'b1;
                end
            end
            reset_parse();
        end
        if (made)
            expected_runs.push_back(r);
    endfunction

    function automatic string format_run(input run_t r);
        return $sformatf("kind=%0d begin=%0d len=%0d align=%0d src=%0d/%0d/%0d/%0d/%0d/%0d/%0d",
                         r.kind, r.start, r.len, r.align, r.src[0], r.src[1], r.src[2],
                         r.src[3], r.src[4], r.src[5], r.src[6]);
    endfunction

    function automatic void check_run();
        run_t got;
        run_t want;
        bit   bad;
        got.kind = run_kind;
        got.start = run_begin;
        got.len = run_length;
        got.align = run_align;
        got.src = {shadow_source, spacing_source, decoration_source, weight_source,
                   color_source, size_source, font_source};
        if (expected_runs.size() == 0)
        begin
            if (mismatch_count < 10)
                $display("unexpected run: %s", format_run(got));
            mismatch_count++;
            return;
        end
        want = expected_runs.pop_front();
        bad = (got.kind !== want.kind) || (got.start !== want.start)
            || (got.len !== want.len) || (got.align !== want.align);
        for (int g = 0; g < GROUPS; g++)
            if (got.src[g] !== want.src[g])
                bad = 1'b1;
        if (bad)
        begin
            if (mismatch_count < 10)
                $display("run mismatch: expected %s, actual %s", format_run(want),
                         format_run(got));
            mismatch_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            text_byte <= '0;
            is_last <= 1'b0;
            send_wait = 0;
            reset_parse();
        end
        else
        begin
            if (in_valid && in_ready)
                parse_byte(text_byte, is_last);
            if (!in_valid || in_ready)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    in_valid <= 1'b0;
                end
                else if (pending_bytes.size() > 0)
                begin
                    next_item = pending_bytes.pop_front();
                    in_valid <= 1'b1;
                    text_byte <= next_item.b;
                    is_last <= next_item.last;
                    send_wait = no_idle ? 0 : $urandom_range(0, 5);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_wait = 0;
            hold_left = 0;
            hold_seen = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_run();
                recv_wait = no_idle ? 0 : $urandom_range(0, 5);
            end
            if (hold_order != hold_seen)
            begin
                hold_seen = hold_order;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles < QUIET_LIMIT)
            quiet_cycles <= quiet_cycles + 1;
        else
        begin
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [FLAGS_W-1:0] rand_flags();
        return FLAGS_W'({$urandom, $urandom});
    endfunction

    task automatic write_flags(input logic idx, input logic [FLAGS_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_FLAGS_LOW)
            flags_low = val;
        else
            flags_high = val;
    endtask

    task automatic settle();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || in_valid || expected_runs.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            draft.push_back(s[i]);
    endfunction

    function automatic void flush_draft();
        byte_item_t item;
        for (int i = 0; i < draft.size(); i++)
        begin
            item.b = draft[i];
            item.last = (i == draft.size() - 1);
            pending_bytes.push_back(item);
        end
        queued_total += draft.size();
        draft.delete();
    endfunction

    function automatic logic [7:0] rand_text_byte();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            8:
            begin
                b = $urandom_range(0, 255);
                if (b == CHAR_LBRACKET)
                    b = "A";
            end
            9: b = CHAR_BACKSLASH;
            default: b = 8'("a") + 8'($urandom_range(0, 25));
        endcase
        return b;
    endfunction

    function automatic void add_token();
        logic [7:0] b;
        logic [7:0] align_codes[4];
        align_codes = '{CHAR_L, CHAR_C, CHAR_R, CHAR_J};
        case ($urandom_range(0, 9))
            0: draft.push_back(CHAR_N);
            1: draft.push_back(align_codes[$urandom_range(0, 3)]);
            2, 3: draft.push_back(CHAR_DIGIT_0 + 8'($urandom_range(0, 9)));
            4, 5: add_text($sformatf("%02d", $urandom_range(0, 19)));
            6: add_text($sformatf("%0d", $urandom_range(16, 70000)));
            7: ;
            8:
            begin
                b = $urandom_range(0, 5);
                draft.push_back(b < 4 ? align_codes[b] : (b == 4 ? CHAR_N : CHAR_DIGIT_0 + 8'd3));
                draft.push_back(8'("a") + 8'($urandom_range(0, 25)));
            end
            default:
            begin
                b = $urandom_range(0, 255);
                if (b == CHAR_PIPE || b == CHAR_RBRACKET)
                    b = "x";
                draft.push_back(b);
            end
        endcase
    endfunction

    function automatic void add_random_string();
        int mode;
        int cut;
        mode = $urandom_range(0, 9);
        if (mode == 0)
        begin
            repeat ($urandom_range(1, 12)) draft.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(1, 4))
            begin
                repeat ($urandom_range(0, 6)) draft.push_back(rand_text_byte());
                if ($urandom_range(0, 5) == 0)
                begin
                    if ($urandom_range(0, 1) != 0)
                        add_text("\\[");
                    else
                        add_text("\\\\[");
                end
                draft.push_back(CHAR_LBRACKET);
                for (int t = $urandom_range(1, 4); t > 0; t--)
                begin
                    add_token();
                    if (t > 1)
                        draft.push_back(CHAR_PIPE);
                end
                if ($urandom_range(0, 9) != 0)
                    draft.push_back(CHAR_RBRACKET);
            end
            repeat ($urandom_range(0, 5)) draft.push_back(rand_text_byte());
            if (mode == 1)
            begin
                cut = $urandom_range(1, draft.size());
                draft = draft[0:cut-1];
                draft[$urandom_range(0, cut - 1)] = $urandom_range(0, 255);
            end
        end
        flush_draft();
    endfunction

    task automatic random_phase(input int count);
        int stop;
        stop = queued_total + count;
        while (queued_total < stop)
            add_random_string();
        settle();
    endtask

    initial
    begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_flags(CFG_FLAGS_LOW, rand_flags());
        write_flags(CFG_FLAGS_HIGH, rand_flags());
        @(negedge clk);
        draft.push_back(8'h00);
        draft.push_back(8'hFF);
        add_text("\\[[c|7|n|12|99||j]x");
        flush_draft();
        add_text("[l|n");
        flush_draft();
        add_text("[r|3][05]");
        flush_draft();
        settle();

        write_flags(CFG_FLAGS_LOW, {FLAGS_W{1'b1}});
        write_flags(CFG_FLAGS_HIGH, {FLAGS_W{1'b1}});
        @(negedge clk);
        random_phase(160);

        write_flags(CFG_FLAGS_LOW, '0);
        write_flags(CFG_FLAGS_HIGH, '0);
        @(negedge clk);
        no_idle = 1'b1;
        random_phase(130);

        write_flags(CFG_FLAGS_LOW, rand_flags());
        write_flags(CFG_FLAGS_HIGH, rand_flags());
        @(negedge clk);
        hold_order++;
        repeat (10)
        begin
            add_text("[n|4]ab");
            flush_draft();
        end
        settle();
        no_idle = 1'b0;

        write_flags(CFG_FLAGS_HIGH, {FLAGS_W{1'b1}});
        @(negedge clk);
        random_phase(220);

        write_flags(CFG_FLAGS_LOW, {FLAGS_W{1'b1}});
        write_flags(CFG_FLAGS_HIGH, rand_flags());
        @(negedge clk);
        random_phase(150);

        write_flags(CFG_FLAGS_LOW, rand_flags());
        write_flags(CFG_FLAGS_HIGH, rand_flags());
        @(negedge clk);
        no_idle = 1'b1;
        add_text("[3|c]aaaa[n|5]bbbb[x[yz");
        flush_draft();
        settle();

        mismatch_count += expected_runs.size();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/smrs_pkg.sv
rtl/core/smrs_style_lookup.sv
rtl/core/styled_markup_run_splitter.sv
dv/styled_markup_run_splitter_tb.sv
